@@ hw/rtl/modular_exponentiation_prime_field_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the prime field exponentiation block
// Shared property forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_PRIME_FIELD_ASSERT_SVH
`define MODULAR_EXPONENTIATION_PRIME_FIELD_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define MEPF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define MEPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/mepf_pkg.sv @@
// ----------------------------------------------------------------------------
// mepf_pkg
// Constants and types for modular exponentiation over the field of order
// 2^64 - 2^32 + 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mepf_pkg;

   localparam int WordWidth = 64;
   localparam int HalfWidth = 32;
   localparam int ProdWidth = 128;

   // Field prime and the low-half mask (2^64 mod P)
   localparam logic [WordWidth-1:0] FieldP = 64'hFFFF_FFFF_0000_0001;
   localparam logic [WordWidth-1:0] Lo32   = 64'h0000_0000_FFFF_FFFF;

   typedef logic [WordWidth-1:0] word_type;
   typedef logic [HalfWidth-1:0] half_type;
   typedef logic [ProdWidth-1:0] prod_type;

   // Sequencer states, one-hot
   typedef enum logic [6:0] {
      ST_IDLE = 7'b000_0001,
      ST_SCAN = 7'b000_0010,
      ST_MUL  = 7'b000_0100,
      ST_RED1 = 7'b000_1000,
      ST_RED2 = 7'b001_0000,
      ST_RED3 = 7'b010_0000,
      ST_DONE = 7'b100_0000
   } state_type;

endpackage

@@ hw/rtl/modular_exponentiation_prime_field.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation_prime_field
// Computes base^exponent mod 2^64 - 2^32 + 1 by right-to-left
// square-and-multiply through one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_base, req_exponent) is taken when req_valid and req_ready
//   are both high. req_ready is high only while the block is idle. The base
//   is reduced modulo the prime as it is captured.
//   The result leaves on rsp_power with rsp_valid/rsp_ready. It is held in
//   its register until taken; a stalled receiver simply keeps the block busy
//   and no new request is taken meanwhile.
//   Each field multiply runs 4 partial products through the one 32x32
//   multiplier, then 3 reduction steps. The exponent is scanned from its
//   low end: each set bit costs a multiply into the accumulator and each
//   bit below the top set bit a square of the base; a zero exponent goes
//   straight to the result. A new request is taken only after the result
//   has been taken and the block has returned to idle.
//   Reset (synchronous, active high) returns the sequencer to idle and
//   drops any pending result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "modular_exponentiation_prime_field_assert.svh"

module modular_exponentiation_prime_field (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mepf_pkg::word_type   req_base,
   input  mepf_pkg::word_type   req_exponent,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mepf_pkg::word_type   rsp_power
);
   import mepf_pkg::*;

   state_type state_ff, state_in;
   word_type  base_ff, base_in;
   word_type  exp_ff, exp_in;
   word_type  acc_ff, acc_in;
   prod_type  prod_ff, prod_in;
   word_type  t0_ff, t0_in;
   word_type  t1_ff, t1_in;
   word_type  r_ff, r_in;
   logic [1:0] pp_cnt_ff, pp_cnt_in;
   logic      op_sq_ff, op_sq_in;

   half_type  a_half;
   half_type  b_half;
   word_type  pp;
   prod_type  pp_addend;
   word_type  hh_ext;
   word_type  hl_ext;
   word_type  lo_word;
   logic [WordWidth:0] sum_wide;
   word_type  reduced;
   word_type  req_base_red;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_power = acc_ff;

   // Shared multiplier: pick the halves for this partial product
   always_comb begin
      if (op_sq_ff) begin
         a_half = pp_cnt_ff[0] ? base_ff[63:32] : base_ff[31:0];
      end else begin
         a_half = pp_cnt_ff[0] ? acc_ff[63:32] : acc_ff[31:0];
      end
      b_half = pp_cnt_ff[1] ? base_ff[63:32] : base_ff[31:0];
      pp = {32'd0, a_half} * {32'd0, b_half};
   end

   // Align the partial product by its half positions
   always_comb begin
      case (pp_cnt_ff)
         2'd0:    pp_addend = {64'd0, pp};
         2'd3:    pp_addend = {pp, 64'd0};
         default: pp_addend = {32'd0, pp, 32'd0};
      endcase
   end

   // Reduction pieces of the 128-bit product
   assign hh_ext   = {32'd0, prod_ff[127:96]};
   assign hl_ext   = {32'd0, prod_ff[95:64]};
   assign lo_word  = prod_ff[63:0];
   assign sum_wide = {1'b0, t0_ff} + {1'b0, t1_ff};
   assign reduced  = (r_ff >= FieldP) ? (r_ff - FieldP) : r_ff;
   assign req_base_red = (req_base >= FieldP) ? (req_base - FieldP) : req_base;

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      base_in   = base_ff;
      exp_in    = exp_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      t0_in     = t0_ff;
      t1_in     = t1_ff;
      r_in      = r_ff;
      pp_cnt_in = pp_cnt_ff;
      op_sq_in  = op_sq_ff;

      case (state_ff)
         ST_IDLE: begin
            // capture the request with the base already reduced
            if (req_valid) begin
               base_in  = req_base_red;
               exp_in   = req_exponent;
               acc_in   = 64'd1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // finish, or launch a multiply for a set bit, else a square
            if (exp_ff == 64'd0) begin
               state_in = ST_DONE;
            end else begin
               op_sq_in  = ~exp_ff[0];
               prod_in   = '0;
               pp_cnt_in = 2'd0;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            // accumulate one partial product per cycle
            prod_in   = prod_ff + pp_addend;
            pp_cnt_in = pp_cnt_ff + 2'd1;
            if (pp_cnt_ff == 2'd3) begin
               state_in = ST_RED1;
            end
         end
         ST_RED1: begin
            // fold the top word: 2^96 = -1 and 2^64 = 2^32 - 1
            t0_in = lo_word - hh_ext;
            if (lo_word < hh_ext) begin
               t0_in = lo_word - hh_ext - Lo32;
            end
            t1_in    = {prod_ff[95:64], 32'd0} - hl_ext;
            state_in = ST_RED2;
         end
         ST_RED2: begin
            // add the folded parts and fix up the carry
            r_in     = sum_wide[63:0] + (sum_wide[WordWidth] ? Lo32 : 64'd0);
            state_in = ST_RED3;
         end
         ST_RED3: begin
            if (op_sq_ff) begin
               // square done: advance to the next exponent bit
               base_in  = reduced;
               exp_in   = {1'b0, exp_ff[63:1]};
               state_in = ST_SCAN;
            end else begin
               acc_in = reduced;
               if (exp_ff[63:1] == 63'd0) begin
                  // last bit: drop the trailing square
                  exp_in   = 64'd0;
                  state_in = ST_SCAN;
               end else begin
                  op_sq_in  = 1'b1;
                  prod_in   = '0;
                  pp_cnt_in = 2'd0;
                  state_in  = ST_MUL;
               end
            end
         end
         ST_DONE: begin
            // hold the result until it is taken
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      base_ff   <= base_in;
      exp_ff    <= exp_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      t0_ff     <= t0_in;
      t1_ff     <= t1_in;
      r_ff      <= r_in;
      pp_cnt_ff <= pp_cnt_in;
      op_sq_ff  <= op_sq_in;
   end

   // Checks
   `MEPF_ASSERT_NOW(a_idle_or_done, clock, reset, rsp_valid, !req_ready,
      "result and request ready together")
   `MEPF_ASSERT_NOW(a_power_in_field, clock, reset, rsp_valid, rsp_power < FieldP,
      "result not reduced")
   `MEPF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready,
      !req_ready && !rsp_valid, "not busy after accept")
   `MEPF_ASSERT_NEXT(a_red_follows_mul, clock, reset,
      (state_ff == ST_MUL) && (pp_cnt_ff == 2'd3), state_ff == ST_RED1,
      "reduction not started")

endmodule
